@@ sv/snp_pkg.sv @@
package snp_pkg;

    localparam int VALUE_BITS = 64;
    localparam int COUNT_OUT_BITS = 16;
    localparam int BASE_BITS = 6;
    localparam int INDEX_BITS = 2;

    localparam logic [INDEX_BITS-1:0] REG_NUMBER_BASE = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_LOWER_CLAMP = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_UPPER_CLAMP = 2'd2;

    localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_MAX = 6'd36;
    localparam logic [BASE_BITS-1:0] LETTER_OFFSET = 6'd10;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic signed [VALUE_BITS-1:0] SIGNED_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [VALUE_BITS-1:0] SIGNED_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [COUNT_OUT_BITS-1:0] COUNT_OUT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } snp_phase_t;

    typedef struct packed {
        logic                  is_digit;
        logic [BASE_BITS-1:0]  value;
    } snp_digit_t;

    // finished parse, before sign handling
    typedef struct packed {
        logic [VALUE_BITS-1:0]     magnitude;
        logic                      negative;
        logic [COUNT_OUT_BITS-1:0] count;
    } snp_rec_t;

    // signed and saturated, before clamping
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [COUNT_OUT_BITS-1:0]    count;
    } snp_sat_t;

    function automatic snp_digit_t digit_of(input logic [7:0] c);
        snp_digit_t r;
        r.is_digit = 1'b1;
        r.value = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            r.value = BASE_BITS'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r.value = BASE_BITS'(c - CHAR_UPPER_A) + LETTER_OFFSET;
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            r.value = BASE_BITS'(c - CHAR_LOWER_A) + LETTER_OFFSET;
        end
        else
        begin
            r.is_digit = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ sv/saturating_signed_number_parser_core.sv @@
// The digit step (64x6 multiply-add) is combinational, ahead of the parse record register.
// Throughput: one text byte per cycle, unless a finishing byte waits on a full record.
// Stages: input register, parse record register, sign/saturate register, clamp/output register.
// Reset (rst_n low, async): pipeline empty, parse idle, base 10, clamps at signed limits.
// Config writes take effect on the next cycle and are expected only while idle.
module saturating_signed_number_parser_core
    import snp_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [INDEX_BITS-1:0]         cfg_index,
    input  logic [VALUE_BITS-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    text_byte,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_BITS-1:0]  parsed_value,
    output logic [COUNT_OUT_BITS-1:0]     bytes_used
);

    logic [BASE_BITS-1:0]          number_base_reg;
    logic signed [VALUE_BITS-1:0]  lower_clamp_reg;
    logic signed [VALUE_BITS-1:0]  upper_clamp_reg;

    logic     rec_valid;
    logic     rec_ready;
    snp_rec_t rec;
    logic     sat_valid;
    logic     sat_ready;
    snp_sat_t sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_RESET;
            lower_clamp_reg <= SIGNED_MIN;
            upper_clamp_reg <= SIGNED_MAX;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NUMBER_BASE: number_base_reg <= cfg_data[BASE_BITS-1:0];
                REG_LOWER_CLAMP: lower_clamp_reg <= $signed(cfg_data);
                REG_UPPER_CLAMP: upper_clamp_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    snp_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .number_base (number_base_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec         (rec)
    );

    snp_sign u_sign (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .sat_valid (sat_valid),
        .sat_ready (sat_ready),
        .sat       (sat)
    );

    snp_clamp u_clamp (
        .clk          (clk),
        .rst_n        (rst_n),
        .lower_clamp  (lower_clamp_reg),
        .upper_clamp  (upper_clamp_reg),
        .sat_valid    (sat_valid),
        .sat_ready    (sat_ready),
        .sat          (sat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parsed_value (parsed_value),
        .bytes_used   (bytes_used)
    );

endmodule

@@ sv/snp_parse.sv @@
module snp_parse
    import snp_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BASE_BITS-1:0] number_base,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output snp_rec_t             rec
);

    localparam int CW = (COUNT_BITS > COUNT_OUT_BITS) ? COUNT_BITS : COUNT_OUT_BITS;
    localparam int PROD_BITS = VALUE_BITS + BASE_BITS;

    // input register
    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;

    // parse state
    snp_phase_t              phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;

    // record register
    logic     rec_valid_reg;
    snp_rec_t rec_reg;

    logic                  in_parse;
    logic                  is_minus;
    logic                  digit_ok;
    logic                  ovf;
    logic                  ended;
    logic                  emit;
    logic                  a_fire;
    logic                  rec_free;
    logic [BASE_BITS-1:0]  base_eff;
    snp_digit_t            dig;
    logic [PROD_BITS-1:0]  prod;
    logic [VALUE_BITS-1:0] acc_step;
    logic                  neg_step;
    logic [COUNT_BITS-1:0] count_step;
    logic [CW-1:0]         count_wide;
    logic [COUNT_OUT_BITS-1:0] count_out;

    always_comb
    begin
        priority if (number_base < BASE_MIN)
            base_eff = BASE_MIN;
        else if (number_base > BASE_MAX)
            base_eff = BASE_MAX;
        else
            base_eff = number_base;
    end

    assign dig = digit_of(a_byte_reg);
    assign in_parse = (phase_reg == PH_START) || (phase_reg == PH_DIGITS);
    assign is_minus = (phase_reg == PH_START) && (a_byte_reg == CHAR_MINUS);
    assign digit_ok = dig.is_digit && (dig.value < base_eff);
    // overflow when acc * base + d no longer fits in 64 bits
    assign prod = PROD_BITS'(acc_reg) * PROD_BITS'(base_eff) + PROD_BITS'(dig.value);
    assign ovf = |prod[PROD_BITS-1:VALUE_BITS];
    assign ended = in_parse && !is_minus && (!digit_ok || ovf);
    assign emit = in_parse && (ended || a_last_reg);

    assign rec_free = !rec_valid_reg || rec_ready;
    assign a_fire = a_valid_reg && (!emit || rec_free);
    assign in_ready = !a_valid_reg || a_fire;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (a_fire)
        begin
            unique case (phase_reg)
                PH_START, PH_DIGITS: phase_next = ended ? PH_DONE : PH_DIGITS;
                PH_DONE:             phase_next = PH_DONE;
                default:             phase_next = PH_DONE;
            endcase
            if (a_last_reg)
                phase_next = PH_START;
        end
    end

    // datapath
    always_comb
    begin
        acc_step = acc_reg;
        neg_step = neg_reg;
        count_step = count_reg;
        if (is_minus)
        begin
            neg_step = 1'b1;
            count_step = (&count_reg) ? count_reg : count_reg + 1'b1;
        end
        else if (in_parse && digit_ok)
        begin
            acc_step = ovf ? '1 : prod[VALUE_BITS-1:0];
            count_step = (&count_reg) ? count_reg : count_reg + 1'b1;
        end
        count_wide = CW'(count_step);
        count_out = (count_wide > CW'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX
                                                      : count_wide[COUNT_OUT_BITS-1:0];
        acc_next = a_last_reg ? '0 : acc_step;
        neg_next = a_last_reg ? 1'b0 : neg_step;
        count_next = a_last_reg ? '0 : count_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            phase_reg <= PH_START;
            acc_reg <= '0;
            neg_reg <= 1'b0;
            count_reg <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            phase_reg <= phase_next;
            if (a_fire)
            begin
                acc_reg <= acc_next;
                neg_reg <= neg_next;
                count_reg <= count_next;
            end
            if (a_fire && emit)
                rec_valid_reg <= 1'b1;
            else if (rec_ready)
                rec_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_byte_reg <= text_byte;
            a_last_reg <= end_of_text;
        end
        if (a_fire && emit)
        begin
            rec_reg.magnitude <= acc_step;
            rec_reg.negative <= neg_step;
            rec_reg.count <= count_out;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec = rec_reg;

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        a_fire && a_last_reg |=> phase_reg == PH_START && acc_reg == '0 && count_reg == '0)
        else $error("parse state not cleared after last byte");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> !emit)
        else $error("result produced while skipping");

    a_rec_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rec_valid_reg) |-> $past(a_fire && emit))
        else $error("record appeared without a finishing byte");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        a_fire && !a_last_reg |=> count_reg >= $past(count_reg))
        else $error("byte count went down mid-parse");

endmodule

@@ sv/snp_sign.sv @@
module snp_sign
    import snp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rec_valid,
    output logic     rec_ready,
    input  snp_rec_t rec,
    output logic     sat_valid,
    input  logic     sat_ready,
    output snp_sat_t sat
);

    logic     sat_valid_reg;
    snp_sat_t sat_reg;
    snp_sat_t sat_next;

    assign rec_ready = !sat_valid_reg || sat_ready;

    always_comb
    begin
        sat_next.count = rec.count;
        if (rec.negative)
            sat_next.value = rec.magnitude[VALUE_BITS-1] ? SIGNED_MIN
                                                         : -$signed(rec.magnitude);
        else
            sat_next.value = rec.magnitude[VALUE_BITS-1] ? SIGNED_MAX
                                                         : $signed(rec.magnitude);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_valid_reg <= 1'b0;
        else if (rec_ready)
            sat_valid_reg <= rec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rec_ready && rec_valid)
            sat_reg <= sat_next;
    end

    assign sat_valid = sat_valid_reg;
    assign sat = sat_reg;

endmodule

@@ sv/snp_clamp.sv @@
module snp_clamp
    import snp_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_BITS-1:0]  lower_clamp,
    input  logic signed [VALUE_BITS-1:0]  upper_clamp,
    input  logic                          sat_valid,
    output logic                          sat_ready,
    input  snp_sat_t                      sat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_BITS-1:0]  parsed_value,
    output logic [COUNT_OUT_BITS-1:0]     bytes_used
);

    logic                          out_valid_reg;
    logic signed [VALUE_BITS-1:0]  value_reg;
    logic signed [VALUE_BITS-1:0]  value_next;
    logic [COUNT_OUT_BITS-1:0]     count_reg;

    assign sat_ready = !out_valid_reg || out_ready;

    // when the bounds cross, values below the lower bound take it and all others take the upper bound
    always_comb
    begin
        priority if (sat.value < lower_clamp)
            value_next = lower_clamp;
        else if (upper_clamp < sat.value)
            value_next = upper_clamp;
        else
            value_next = sat.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (sat_ready)
            out_valid_reg <= sat_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sat_ready && sat_valid)
        begin
            value_reg <= value_next;
            count_reg <= sat.count;
        end
    end

    assign out_valid = out_valid_reg;
    assign parsed_value = value_reg;
    assign bytes_used = count_reg;

endmodule
